// File: rtl/core/sads_pkg.sv
// ----------------------------------------------------------------------------
// sads_pkg
// Shared types and constants for the two-stacks-in-one-array engine.
// ----------------------------------------------------------------------------
package sads_pkg;

  localparam int WORD_WIDTH      = 32;
  localparam int STORE_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef struct packed {
    action_t               action;
    logic                  stack_select;
    logic [WORD_WIDTH-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] read_value;
    status_t               status;
    logic                  low_empty;
    logic                  high_empty;
  } rsp_t;

  // Per-operation info carried alongside the memory read.
  typedef struct packed {
    logic    rd;
    status_t status;
    logic    low_empty;
    logic    high_empty;
  } op_info_t;

endpackage

// File: rtl/core/sads_mem.sv
// ----------------------------------------------------------------------------
// sads_mem
// Single-port synchronous word store with a registered read.
// ----------------------------------------------------------------------------
module sads_mem #(
  parameter int STORE_DEPTH = sads_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic                            re,
  input  logic [AW-1:0]                   addr,
  input  logic [sads_pkg::WORD_WIDTH-1:0] wdata,
  output logic [sads_pkg::WORD_WIDTH-1:0] rdata
);
  import sads_pkg::*;

  logic [WORD_WIDTH-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/core/sads_ptr.sv
// ----------------------------------------------------------------------------
// sads_ptr
// Stack top counters, bounds checks and store address generation.
// ----------------------------------------------------------------------------
module sads_ptr #(
  parameter int STORE_DEPTH = sads_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  sads_pkg::cmd_t     cmd,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output sads_pkg::op_info_t info
);
  import sads_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [CW:0]   DEPTH_W = (CW+1)'(STORE_DEPTH);

  logic [CW-1:0] low_count, low_count_next;
  logic [CW-1:0] high_count, high_count_next;
  logic          full;
  logic [CW-1:0] lo_top, hi_push, hi_top;
  logic          sel_empty;

  assign full      = ({1'b0, low_count} + {1'b0, high_count}) >= DEPTH_W;
  assign lo_top    = low_count - CW'(1);
  assign hi_push   = DEPTH_C - high_count - CW'(1);
  assign hi_top    = DEPTH_C - high_count;
  assign sel_empty = cmd.stack_select ? (high_count == '0) : (low_count == '0);

  always_comb begin
    low_count_next  = low_count;
    high_count_next = high_count;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = cmd.stack_select ? hi_top[AW-1:0] : lo_top[AW-1:0];
    info.rd         = 1'b0;
    info.status     = ST_OK;
    unique case (cmd.action)
      ACT_PUSH: begin
        mem_addr = cmd.stack_select ? hi_push[AW-1:0] : low_count[AW-1:0];
        if (full) begin
          info.status = ST_OVERFLOW;
        end else begin
          mem_we = accept;
          if (cmd.stack_select) begin
            high_count_next = high_count + CW'(1);
          end else begin
            low_count_next = low_count + CW'(1);
          end
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (sel_empty) begin
          info.status = ST_UNDERFLOW;
        end else begin
          mem_re  = accept;
          info.rd = 1'b1;
          if (cmd.action == ACT_POP) begin
            if (cmd.stack_select) begin
              high_count_next = high_count - CW'(1);
            end else begin
              low_count_next = low_count - CW'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
    info.low_empty  = (low_count_next == '0);
    info.high_empty = (high_count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_count  <= '0;
      high_count <= '0;
    end else if (accept) begin
      low_count  <= low_count_next;
      high_count <= high_count_next;
    end
  end

endmodule

// File: rtl/core/shared_array_double_stack.sv
// ----------------------------------------------------------------------------
// shared_array_double_stack
// Two LIFO stacks sharing one word store; low stack grows up from entry 0,
// high stack grows down from the last entry.
// Response path: the store read and the p1 register take the command at its
//   transfer; rsp_valid rises when p1 advances into the output register.
// Throughput: one command per cycle while cmd_stall is low; the single store
//   port is used at most once per command, counters update at the transfer.
// Reset: synchronous, clears both counters and the pipeline valids; store
//   contents are left undefined (never read before written).
// ----------------------------------------------------------------------------
module shared_array_double_stack #(
  parameter int STORE_DEPTH = sads_pkg::STORE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  sads_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sads_pkg::rsp_t rsp
);
  import sads_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic                  accept;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [WORD_WIDTH-1:0] mem_rdata;
  op_info_t              info;

  // p1: command issued to the store, read data arriving this cycle
  logic                  p1_valid;
  op_info_t              p1_info;
  logic                  advance;

  // p1 moves into the output register when that register is free or draining
  assign advance   = p1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = p1_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  sads_ptr #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_ptr (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .info     (info)
  );

  // Counters update at the transfer, so a pop right after a push reads
  // an entry whose write has already landed: no forwarding needed.
  sads_mem #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (cmd.push_value),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_info <= info;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.read_value <= p1_info.rd ? mem_rdata : '0;
      rsp.status     <= p1_info.status;
      rsp.low_empty  <= p1_info.low_empty;
      rsp.high_empty <= p1_info.high_empty;
    end
  end

  // ---- assertions ----
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.read_value == '0)
    else $error("error response carries nonzero data");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> p1_valid && rsp_valid && rsp_stall)
    else $error("command stalled without a blocked pipeline");

  a_issue: assert property (@(posedge clk) disable iff (rst)
    accept |=> p1_valid)
    else $error("accepted command lost before output stage");

  a_no_rsvd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status != ST_RSVD)
    else $error("reserved status code on response");

endmodule

// File: tb/tb_shared_array_double_stack.sv
// ----------------------------------------------------------------------------
// tb_shared_array_double_stack
// Self-checking bench for the two-stacks-in-one-array engine. A scoreboard
// keeps its own copy of the shared store and both top counters, predicts the
// response of every accepted command and checks the responses in order.
// Stimulus: a short directed pass over the empty, edge-value and NOP cases,
// then random fill / drain / mixed segments that push the store to full and
// back, with random idle bursts on both channels.
// ----------------------------------------------------------------------------

class stack_scoreboard;
  localparam int DEPTH = sads_pkg::STORE_DEPTH_DEF;

  logic [sads_pkg::WORD_WIDTH-1:0] words [DEPTH];
  int             low_cnt;
  int             high_cnt;
  sads_pkg::rsp_t awaited[$];
  int             mismatches;
  int             checked;
  int             overflows;
  int             underflows;
  int             peak;

  // One stack operation against the shadow store.
  function sads_pkg::rsp_t predict_stack_op(sads_pkg::cmd_t c);
    sads_pkg::rsp_t r;
    int             held;
    r        = '0;
    r.status = sads_pkg::ST_OK;
    case (c.action)
      sads_pkg::ACT_PUSH: begin
        if (low_cnt + high_cnt >= DEPTH) begin
          r.status = sads_pkg::ST_OVERFLOW;
          overflows++;
        end else if (!c.stack_select) begin
          words[low_cnt] = c.push_value;
          low_cnt++;
        end else begin
          high_cnt++;
          words[DEPTH - high_cnt] = c.push_value;
        end
        if (low_cnt + high_cnt > peak) peak = low_cnt + high_cnt;
      end
      sads_pkg::ACT_POP, sads_pkg::ACT_PEEK: begin
        held = c.stack_select ? high_cnt : low_cnt;
        if (held == 0) begin
          r.status = sads_pkg::ST_UNDERFLOW;
          underflows++;
        end else begin
          r.read_value = c.stack_select ? words[DEPTH - high_cnt] : words[low_cnt - 1];
          if (c.action == sads_pkg::ACT_POP) begin
            if (c.stack_select) high_cnt--;
            else low_cnt--;
          end
        end
      end
      default: ;
    endcase
    r.low_empty  = (low_cnt == 0);
    r.high_empty = (high_cnt == 0);
    return r;
  endfunction

  function void note_cmd(sads_pkg::cmd_t c);
    awaited.push_back(predict_stack_op(c));
  endfunction

  function void report(string what, sads_pkg::rsp_t want, sads_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"MISMATCH %s: expected value=%h status=%0d le=%0b he=%0b,",
                " got value=%h status=%0d le=%0b he=%0b"},
               what, want.read_value, want.status, want.low_empty, want.high_empty,
               got.read_value, got.status, got.low_empty, got.high_empty);
  endfunction

  function void check_rsp(sads_pkg::rsp_t got);
    sads_pkg::rsp_t want;
    checked++;
    if (awaited.size() == 0) begin
      report("response with nothing outstanding", '0, got);
      return;
    end
    want = awaited.pop_front();
    if (got.read_value !== want.read_value || got.status !== want.status ||
        got.low_empty !== want.low_empty || got.high_empty !== want.high_empty)
      report($sformatf("response %0d", checked), want, got);
  endfunction
endclass

module tb_shared_array_double_stack;
  import sads_pkg::*;

  localparam int ITEMS     = 1450;
  localparam int CALM_TAIL = 200;   // last commands run with no idling at all

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  stack_scoreboard sb;
  int  sent;          // commands transferred, NOPs excluded
  bit  calm;          // set near the end: no idling on either side
  int  stall_hold;    // cycles left in the current response-side stall burst or free run

  shared_array_double_stack dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop; far above the slowest legal run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Response side: random stall bursts separated by free runs that are sometimes
  // long enough to give stretches with no back-pressure.
  always @(posedge clk) begin
    if (rst || calm) begin
      rsp_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if (!rsp_stall && $urandom_range(0, 2) == 0) begin
      rsp_stall  <= 1'b1;
      stall_hold = $urandom_range(0, 9);
    end else begin
      rsp_stall  <= 1'b0;
      stall_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(0, 30);
    end
  end

  // Every response transfer goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_rsp(rsp);
  end

  function automatic cmd_t mk(action_t a, logic sel, logic [WORD_WIDTH-1:0] v);
    cmd_t c;
    c.action       = a;
    c.stack_select = sel;
    c.push_value   = v;
    return c;
  endfunction

  // push_pct: share of pushes; low_pct: share aimed at the low stack.
  function automatic cmd_t random_cmd(int push_pct, int low_pct);
    int                    r;
    action_t               a;
    logic [WORD_WIDTH-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 3)                 a = ACT_NOP;
    else if (r < 3 + push_pct) a = ACT_PUSH;
    else if ($urandom_range(0, 9) < 7) a = ACT_POP;
    else                       a = ACT_PEEK;
    case ($urandom_range(0, 15))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
    return mk(a, $urandom_range(0, 99) >= low_pct, v);
  endfunction

  // Hold the command until it transfers, then hand it to the scoreboard.
  task automatic send_cmd(cmd_t c);
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_cmd(c);
  endtask

  task automatic idle_cmd(int n);
    cmd_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drive(cmd_t c, bit gappy);
    if (sent >= ITEMS - CALM_TAIL) calm = 1'b1;
    if (gappy && !calm && $urandom_range(0, 5) == 0) idle_cmd($urandom_range(1, 10));
    send_cmd(c);
    if (c.action != ACT_NOP) sent++;
  endtask

  initial begin
    int seg;
    int len;
    int push_pct;
    int low_pct;
    bit gappy;

    sb = new;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: underflow on both empty stacks, NOPs, edge values on both
    // stacks, peek leaving the top alone, pop down to underflow again.
    drive(mk(ACT_POP,  1'b0, '0), 1'b1);
    drive(mk(ACT_PEEK, 1'b1, '0), 1'b1);
    drive(mk(ACT_POP,  1'b1, '1), 1'b1);
    drive(mk(ACT_PEEK, 1'b0, '1), 1'b1);
    drive(mk(ACT_NOP,  1'b0, '1), 1'b1);
    drive(mk(ACT_NOP,  1'b1, '0), 1'b1);
    drive(mk(ACT_PUSH, 1'b0, '0), 1'b1);
    drive(mk(ACT_PUSH, 1'b0, '1), 1'b1);
    drive(mk(ACT_PUSH, 1'b1, '1), 1'b1);
    drive(mk(ACT_PUSH, 1'b1, '0), 1'b1);
    drive(mk(ACT_PEEK, 1'b0, '0), 1'b1);
    drive(mk(ACT_PEEK, 1'b1, '0), 1'b1);
    drive(mk(ACT_NOP,  1'b1, 32'hA5A5_5A5A), 1'b1);
    drive(mk(ACT_POP,  1'b0, '0), 1'b1);
    drive(mk(ACT_POP,  1'b0, '0), 1'b1);
    drive(mk(ACT_POP,  1'b0, '0), 1'b1);
    drive(mk(ACT_POP,  1'b1, '0), 1'b1);
    drive(mk(ACT_POP,  1'b1, '0), 1'b1);
    drive(mk(ACT_PEEK, 1'b1, '0), 1'b1);
    drive(mk(ACT_PUSH, 1'b0, 32'hA5A5_5A5A), 1'b1);
    drive(mk(ACT_PUSH, 1'b1, 32'h5A5A_A5A5), 1'b1);
    drive(mk(ACT_POP,  1'b1, '0), 1'b1);
    drive(mk(ACT_POP,  1'b0, '0), 1'b1);

    // Random segments. The first is push-heavy and long enough to run the
    // store full and hit overflow; later ones fill, drain, mix or lean on
    // one stack so the meeting point of the two tops moves around.
    seg = 0;
    while (sent < ITEMS) begin
      if (seg == 0) begin
        push_pct = 92;
        low_pct  = 50;
        len      = 330;
        gappy    = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0:       push_pct = 85;
          1:       push_pct = 10;
          2:       push_pct = 45;
          default: push_pct = 70;
        endcase
        low_pct = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) * 100)
                                              : $urandom_range(20, 80);
        len     = $urandom_range(40, 300);
        gappy   = ($urandom_range(0, 3) != 0);
      end
      for (int k = 0; k < len && sent < ITEMS; k++)
        drive(random_cmd(push_pct, low_pct), gappy);
      // Let the pipe run dry once with the store full.
      if (seg == 0) begin
        cmd_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
      end
      seg++;
    end

    cmd_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d stack commands in %0d segments; %0d responses checked, %0d mismatches.",
             sent, seg, sb.checked, sb.mismatches);
    $display("Saw %0d overflow and %0d underflow responses; peak occupancy %0d of %0d words.",
             sb.overflows, sb.underflows, sb.peak, STORE_DEPTH_DEF);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/sads_pkg.sv
rtl/core/sads_mem.sv
rtl/core/sads_ptr.sv
rtl/core/shared_array_double_stack.sv
tb/tb_shared_array_double_stack.sv
